[hw/rtl/olst_pkg.sv]
// Shared command and status codes and the result bundle of the ordered list store.
package olst_pkg;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_ERASE  = 2'd1;
	localparam logic [1:0] CMD_GET    = 2'd2;
	localparam logic [1:0] CMD_SPARE  = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_RANGE     = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 9;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [1:0]               status;
		logic [COUNT_W-1:0]       element_count;
	} res_t;

endpackage

[hw/rtl/olst_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module olst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/olst_ctrl.sv]
// Command sequencer: append, read, and the erase scan and shift over the element RAM.
module olst_ctrl #(
	parameter int CAPACITY = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        cmd,
	input  logic signed [olst_pkg::DATA_W-1:0] item_value,
	input  logic [olst_pkg::POS_W-1:0]        position,
	input  logic                              slot_free,
	output logic                              done_valid,
	output olst_pkg::res_t                    done_res,
	output logic                              mem_we,
	output logic [$clog2(CAPACITY)-1:0]       mem_waddr,
	output logic [olst_pkg::DATA_W-1:0]       mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(CAPACITY)-1:0]       mem_raddr,
	input  logic [olst_pkg::DATA_W-1:0]       mem_rdata
);
	import olst_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_GETW  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic              pend_s1;
	logic [AW-1:0]     pend_idx_s1;
	logic [DATA_W-1:0] val_q;
	res_t              res_q;

	logic full;
	logic in_range;
	logic accept;
	logic more;
	logic hit;

	assign full      = (count_q == CW'(CAPACITY));
	assign in_range  = (PW'(position) < PW'(count_q));
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign more      = (idx_q < count_q);
	assign hit       = pend_s1 && (mem_rdata == val_q);

	assign done_valid = (state_q == S_DONE);
	assign done_res   = res_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd == CMD_APPEND && !full) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(count_q);
					mem_wdata = item_value;
				end
				if (accept && cmd == CMD_GET && in_range) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(position);
				end
			end
			S_SCAN: begin
				mem_re    = more;
				mem_raddr = AW'(idx_q);
			end
			S_SHIFT: begin
				mem_re    = more;
				mem_raddr = AW'(idx_q);
				// pull each later element one place towards the front
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pend_idx_s1 - 1'b1);
					mem_wdata = mem_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			pend_idx_s1 <= '0;
			val_q       <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q.read_data     <= '0;
						res_q.status        <= STAT_OK;
						res_q.element_count <= COUNT_W'(count_q);
						state_q             <= S_DONE;
						unique case (cmd)
							CMD_APPEND: begin
								if (full) begin
									res_q.status <= STAT_FULL;
								end else begin
									count_q             <= count_q + 1'b1;
									res_q.element_count <= COUNT_W'(count_q + 1'b1);
								end
							end
							CMD_ERASE: begin
								val_q   <= item_value;
								idx_q   <= '0;
								pend_s1 <= 1'b0;
								state_q <= S_SCAN;
							end
							CMD_GET: begin
								if (in_range) begin
									state_q <= S_GETW;
								end else begin
									res_q.status <= STAT_RANGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_GETW: begin
					res_q.read_data <= mem_rdata;
					state_q         <= S_DONE;
				end
				S_SCAN: begin
					priority if (hit) begin
						// in-flight read is dropped; shift starts one past the match
						idx_q   <= CW'(pend_idx_s1) + 1'b1;
						pend_s1 <= 1'b0;
						state_q <= S_SHIFT;
					end else if (!pend_s1 && !more) begin
						res_q.status <= STAT_NOT_FOUND;
						state_q      <= S_DONE;
					end else begin
						pend_s1     <= more;
						pend_idx_s1 <= AW'(idx_q);
						if (more) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SHIFT: begin
					if (!pend_s1 && !more) begin
						count_q             <= count_q - 1'b1;
						res_q.status        <= STAT_OK;
						res_q.element_count <= COUNT_W'(count_q - 1'b1);
						state_q             <= S_DONE;
					end else begin
						pend_s1     <= more;
						pend_idx_s1 <= AW'(idx_q);
						if (more) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ordered_list_store_core.sv]
// Ordered list store top level: sequencer, element RAM and result register.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+------------------------------------
//  request | req_valid | req_ready | cmd, item_value, position
//  result  | res_valid | res_ready | read_data, status, element_count
//
// For append and unused codes the result passes through the sequencer's result register and
// the output register before res_valid rises; a read also waits in the read-wait state.
// Erase scans for the first match and, on a hit, shifts; one RAM read a cycle for the scan,
// then one read and one write a cycle to close the gap.
// Reset clears the count and sequencer state; the element RAM needs no clearing pass.
// One result waits in the output register while the next request is taken; a
// request that finishes before that result is taken holds until it is.
module ordered_list_store_core #(
	parameter int CAPACITY = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [1:0]                         cmd,
	input  logic signed [olst_pkg::DATA_W-1:0]  item_value,
	input  logic [olst_pkg::POS_W-1:0]         position,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [olst_pkg::DATA_W-1:0]  read_data,
	output logic [1:0]                         status,
	output logic [olst_pkg::COUNT_W-1:0]       element_count
);
	import olst_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic              done_valid;
	res_t              done_res;
	logic              slot_free;
	logic              out_v_q;
	res_t              out_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	assign slot_free = !out_v_q || res_ready;

	olst_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.cmd        (cmd),
		.item_value (item_value),
		.position   (position),
		.slot_free  (slot_free),
		.done_valid (done_valid),
		.done_res   (done_res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	olst_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (slot_free) begin
			out_v_q <= done_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && done_valid) begin
			out_q <= done_res;
		end
	end

	assign res_valid     = out_v_q;
	assign read_data     = out_q.read_data;
	assign status        = out_q.status;
	assign element_count = out_q.element_count;

endmodule

[hw/rtl/olst_checker.sv]
// Port-level checks on the ordered list store results, bound to the top level.
module olst_checker #(
	parameter int CAPACITY = 256
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic [1:0]                         cmd,
	input logic signed [olst_pkg::DATA_W-1:0]  item_value,
	input logic [olst_pkg::POS_W-1:0]         position,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [olst_pkg::DATA_W-1:0]  read_data,
	input logic [1:0]                         status,
	input logic [olst_pkg::COUNT_W-1:0]       element_count
);
	import olst_pkg::*;

	localparam logic CNT_EXACT = (CAPACITY <= 256);
	localparam logic [COUNT_W-1:0] CAP9 = COUNT_W'(CAPACITY);

	// a waiting request keeps its payload
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(cmd) && $stable(item_value)
			&& $stable(position))
		else $error("waiting request dropped or changed");

	// a failed request never carries data
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != STAT_OK |-> read_data == '0)
		else $error("read_data non-zero on a failed request");

	// full is reported only with the store at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_FULL && CNT_EXACT |-> element_count == CAP9)
		else $error("store full reported below capacity");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && CNT_EXACT |-> element_count <= CAP9)
		else $error("element_count beyond capacity");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(read_data) && $stable(status)
			&& $stable(element_count))
		else $error("stalled result changed");

endmodule

bind ordered_list_store_core olst_checker #(.CAPACITY(CAPACITY)) u_olst_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the ordered list store: shadow list, request driver, result checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import olst_pkg::*;

	localparam int CAPACITY     = 256;
	localparam int RANDOM_ITEMS = 1880;
	localparam int PHASE_LEN    = 150;
	localparam int PAUSE_AT     = 1000;
	localparam int TAIL_CYCLES  = CAPACITY + 8;
	localparam longint MAX_CYCLES = 64'd3_000_000;

	// Shadow of the list contents and the queue of results still owed by the block.
	class list_shadow;
		logic signed [DATA_W-1:0] shadow_list[$];
		res_t                     due_results[$];
		int errors;
		int n_append, n_full, n_erase, n_miss, n_get, n_range, n_unused, n_results, peak;

		function new();
			errors = 0;
			n_append = 0; n_full = 0; n_erase = 0; n_miss = 0;
			n_get = 0; n_range = 0; n_unused = 0; n_results = 0; peak = 0;
		endfunction

		function int occupancy();
			return shadow_list.size();
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function logic signed [DATA_W-1:0] pick_held();
			return shadow_list[$urandom_range(shadow_list.size() - 1)];
		endfunction

		function void take_request(logic [1:0] c, logic signed [DATA_W-1:0] v,
				logic [POS_W-1:0] p);
			res_t r;
			int   hit;
			r = '0;
			r.status = STAT_OK;
			case (c)
				CMD_APPEND: begin
					n_append++;
					if (shadow_list.size() >= CAPACITY) begin
						r.status = STAT_FULL;
						n_full++;
					end else begin
						shadow_list = {shadow_list, v};
					end
				end
				CMD_ERASE: begin
					n_erase++;
					hit = -1;
					for (int i = 0; i < shadow_list.size(); i++)
						if (hit < 0 && shadow_list[i] == v)
							hit = i;
					if (hit >= 0) begin
						shadow_list.delete(hit);
					end else begin
						r.status = STAT_NOT_FOUND;
						n_miss++;
					end
				end
				CMD_GET: begin
					n_get++;
					if (int'(p) < shadow_list.size()) begin
						r.read_data = shadow_list[p];
					end else begin
						r.status = STAT_RANGE;
						n_range++;
					end
				end
				default: n_unused++;
			endcase
			r.element_count = COUNT_W'(shadow_list.size());
			if (shadow_list.size() > peak)
				peak = shadow_list.size();
			due_results = {due_results, r};
		endfunction

		function void check_result(logic signed [DATA_W-1:0] rd, logic [1:0] st,
				logic [COUNT_W-1:0] ec);
			res_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: read_data %0d status %0d count %0d",
					$time, rd, st, ec);
				errors++;
				return;
			end
			want = due_results.pop_front();
			n_results++;
			if (rd !== want.read_data) begin
				$display("%0t: read_data mismatch: expected %0d, actual %0d",
					$time, want.read_data, rd);
				errors++;
			end
			if (st !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, st);
				errors++;
			end
			if (ec !== want.element_count) begin
				$display("%0t: element_count mismatch: expected %0d, actual %0d",
					$time, want.element_count, ec);
				errors++;
			end
		endfunction
	endclass

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      req_valid  = 1'b0;
	logic                      req_ready;
	logic [1:0]                cmd        = CMD_APPEND;
	logic signed [DATA_W-1:0]  item_value = '0;
	logic [POS_W-1:0]          position   = '0;
	logic                      res_valid;
	logic                      res_ready  = 1'b0;
	logic signed [DATA_W-1:0]  read_data;
	logic [1:0]                status;
	logic [COUNT_W-1:0]        element_count;

	list_shadow  sb = new();
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	longint      cycles = 0;
	logic signed [DATA_W-1:0] value_pool[16];

	ordered_list_store_core #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.item_value(item_value),
		.position(position),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.read_data(read_data),
		.status(status),
		.element_count(element_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(read_data, status, element_count);
	end

	// Called just after a falling edge; returns just after the falling edge that
	// follows acceptance, with valid still high.
	task automatic send_request(logic [1:0] c, logic signed [DATA_W-1:0] v,
			logic [POS_W-1:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= c;
		item_value <= v;
		position   <= p;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.take_request(c, v, p);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic logic signed [DATA_W-1:0] any_value();
		if ($urandom_range(1))
			return value_pool[$urandom_range(15)];
		return $urandom;
	endfunction

	initial begin
		logic [1:0]               c;
		logic signed [DATA_W-1:0] v;
		logic [POS_W-1:0]         p;
		int  roll;
		int  level;
		int  dwell;
		bit  filling;

		value_pool[0] = 32'sh7fffffff;
		value_pool[1] = 32'sh80000000;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (int i = 4; i < 16; i++)
			value_pool[i] = $urandom;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty store, extremes, duplicates, erase at head, middle and tail
		send_request(CMD_GET,    32'sd0,            8'd0);
		send_request(CMD_ERASE,  32'sd5,            8'd0);
		send_request(CMD_SPARE,  -32'sd1,           8'hff);
		send_request(CMD_APPEND, 32'sh7fffffff,     8'h00);
		send_request(CMD_APPEND, 32'sh80000000,     8'hff);
		send_request(CMD_APPEND, 32'sd0,            8'h55);
		send_request(CMD_APPEND, -32'sd1,           8'haa);
		send_request(CMD_APPEND, 32'sh80000000,     8'h00);
		send_request(CMD_GET,    32'sd0,            8'd0);
		send_request(CMD_GET,    -32'sd1,           8'd1);
		send_request(CMD_GET,    32'sd0,            8'd4);
		send_request(CMD_GET,    32'sd0,            8'd5);
		send_request(CMD_GET,    32'sd0,            8'd255);
		send_request(CMD_ERASE,  32'sh80000000,     8'd0);
		send_request(CMD_GET,    32'sd0,            8'd1);
		send_request(CMD_GET,    32'sd0,            8'd3);
		send_request(CMD_ERASE,  32'sd12345,        8'd0);
		send_request(CMD_ERASE,  -32'sd1,           8'd0);
		send_request(CMD_ERASE,  32'sh80000000,     8'd0);
		send_request(CMD_ERASE,  32'sh7fffffff,     8'd0);
		send_request(CMD_GET,    32'sd0,            8'd0);
		send_request(CMD_ERASE,  32'sd0,            8'd0);
		send_request(CMD_SPARE,  32'sd0,            8'd0);
		send_request(CMD_GET,    32'sd0,            8'd0);

		// random: alternate filling to capacity and draining to empty
		filling = 1'b1;
		dwell = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ((n / PHASE_LEN) % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			if (n == PAUSE_AT)
				drain_results();

			level = sb.occupancy();
			if (filling && level == CAPACITY) begin
				dwell++;
				if (dwell > 30) begin
					filling = 1'b0;
					dwell = 0;
				end
			end else if (!filling && level == 0) begin
				dwell++;
				if (dwell > 10) begin
					filling = 1'b1;
					dwell = 0;
				end
			end

			roll = $urandom_range(99);
			v = $urandom;
			p = POS_W'($urandom);
			if (roll < 3)
				c = CMD_SPARE;
			else if (roll < (filling ? 73 : 18))
				c = CMD_APPEND;
			else if (roll < (filling ? 85 : 78))
				c = CMD_ERASE;
			else
				c = CMD_GET;

			case (c)
				CMD_APPEND: v = any_value();
				CMD_ERASE:
					if (level > 0 && $urandom_range(99) < 80)
						v = sb.pick_held();
					else
						v = any_value();
				CMD_GET:
					if (level > 0 && $urandom_range(99) < 80)
						p = POS_W'($urandom_range(level - 1));
				default: ;
			endcase
			send_request(c, v, p);
		end
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d appends (%0d refused as full), %0d erases (%0d unmatched),",
			sb.n_append, sb.n_full, sb.n_erase, sb.n_miss);
		$display("%0d reads (%0d out of range), %0d unused codes, %0d results, peak count %0d",
			sb.n_get, sb.n_range, sb.n_unused, sb.n_results, sb.peak);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/olst_pkg.sv
hw/rtl/olst_ram.sv
hw/rtl/olst_ctrl.sv
hw/rtl/ordered_list_store_core.sv
hw/rtl/olst_checker.sv
dv/testbench.sv
